FILE: rtl/core/hbvt_pkg.sv
// Shared types, constants and score helpers for the bigram Viterbi tagger.
// No dependencies; used by hmm_bigram_viterbi_tagger.
package hbvt_pkg;

   // default sizing
   localparam int MAX_TAGS_DEF     = 64;
   localparam int MAX_LEN_DEF      = 64;
   localparam int MAX_CLASSES_DEF  = 1024;
   localparam int MAX_SUFFIXES_DEF = 4096;
   localparam int LOG_WIDTH_DEF    = 32;

   // score arithmetic width: 50 bits, wider than a three-term sum of 32-bit log values
   localparam int SCORE_W = 50;
   typedef logic signed [SCORE_W-1:0] score_type;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WORD = 1'b1;

   // table selects
   localparam logic [2:0] TBL_BEGIN  = 3'd0;
   localparam logic [2:0] TBL_END    = 3'd1;
   localparam logic [2:0] TBL_TRANS  = 3'd2;
   localparam logic [2:0] TBL_EMIT   = 3'd3;
   localparam logic [2:0] TBL_SUFFIX = 3'd4;

   // register byte addresses
   localparam logic [2:0] CSR_TAG_COUNT = 3'h0;
   localparam logic [2:0] CSR_UNIFORM   = 3'h4;

   localparam logic [31:0] ZERO_PROB_CODE = 32'h8000_0000;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  table_select;
      logic [5:0]  row_tag;
      logic [11:0] column_index;
      logic [31:0] log_value;
      logic [9:0]  word_class;
      logic        in_dictionary;
      logic [11:0] suffix_index;
      logic        suffix_known;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [5:0] tag_out;
      logic [5:0] position_out;
      logic       last_out;
      logic       overflow_out;
   } rsp_type;

   // stored 32-bit code to internal score, clamped to the log range
   function automatic score_type code_to_score(logic [31:0] u, score_type lo, score_type hi);
      score_type v;
      v = score_type'($signed(u));
      if (u == ZERO_PROB_CODE) return lo;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // saturating sum of three scores; any zero probability wins
   function automatic score_type sat_add3(score_type a, score_type b, score_type c,
                                          score_type lo, score_type hi);
      score_type s;
      s = a + b + c;
      if (a == lo || b == lo || c == lo) return lo;
      if (s < lo) s = lo;
      if (s > hi) s = hi;
      return s;
   endfunction

endpackage

FILE: rtl/core/hbvt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hbvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/core/hmm_bigram_viterbi_tagger.sv
// Bigram HMM Viterbi tagger. A load beat writes its table on the accepted beat and the
// block stays idle. A word beat, for each tag in use, reads the emission, then runs
// the add-compare-select loop at one transition read per cycle, drains it and writes
// the path score; the first word of a sentence skips the loop and a word past MAX_LEN
// only sets overflow. The last word adds an end scan and a backtrack emitting the tags
// one by one, never held off. Synchronous reset clears control state, not the tables.
module hmm_bigram_viterbi_tagger
   import hbvt_pkg::*;
#(
   parameter int MAX_TAGS     = MAX_TAGS_DEF,
   parameter int MAX_LEN      = MAX_LEN_DEF,
   parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
   parameter int MAX_SUFFIXES = MAX_SUFFIXES_DEF,
   parameter int LOG_WIDTH    = LOG_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int TW   = $clog2(MAX_TAGS);
   localparam int PCW  = $clog2(MAX_LEN + 1);
   localparam int PW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int TRD  = MAX_TAGS * MAX_TAGS;
   localparam int EMD  = MAX_TAGS * MAX_CLASSES;
   localparam int SFD  = MAX_TAGS * MAX_SUFFIXES;
   localparam int PSD  = 2 * MAX_TAGS;
   localparam int BPD  = MAX_LEN * MAX_TAGS;
   localparam int TRA  = $clog2(TRD);
   localparam int EMA  = $clog2(EMD);
   localparam int SFA  = $clog2(SFD);
   localparam int PSA  = $clog2(PSD);
   localparam int BPA  = $clog2(BPD);
   localparam score_type LOG_LO = -(score_type'(1) <<< (LOG_WIDTH - 1));
   localparam score_type LOG_HI = (score_type'(1) <<< (LOG_WIDTH - 1)) - score_type'(1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_EMIT   = 10'b00_0000_0010,
      S_ELAT   = 10'b00_0000_0100,
      S_ACS    = 10'b00_0000_1000,
      S_DRAIN  = 10'b00_0001_0000,
      S_WRITE  = 10'b00_0010_0000,
      S_FSCAN  = 10'b00_0100_0000,
      S_FDRAIN = 10'b00_1000_0000,
      S_BEMIT  = 10'b01_0000_0000,
      S_BWAIT  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [6:0]  tag_count_ff;
   logic [31:0] uniform_ff;

   // control state
   logic [PCW-1:0] pos_ff, pos_in;
   logic           ovf_ff, ovf_in;
   logic [TW-1:0]  i_ff, i_in;
   logic [TW-1:0]  jiss_ff, jiss_in;
   logic [PW-1:0]  p_ff, p_in;
   logic           v1_ff, v2_ff, l1_ff, l2_ff;
   logic [TW-1:0]  j1_ff, j2_ff;

   // item fields held for the word
   logic [9:0]  wc_ff;
   logic [11:0] si_ff;
   logic        dict_ff, wc_ok_ff, suf_ok_ff, last_ff, fin_ff;

   // datapath registers
   score_type     e_ff, s2_ff, best_ff, best_in;
   logic [TW-1:0] bj_ff, bj_in;

   logic accept, load_go, row_ok;
   logic [6:0] n_use;
   logic [TW-1:0] nm1;
   logic issue;

   // memory data
   logic [31:0]          beg_rd, end_rd, tr_rd, em_rd, sf_rd;
   logic [LOG_WIDTH-1:0] ps_rd;
   logic [TW-1:0]        bp_rd;
   score_type            e_conv, s1_sum;

   assign accept  = start && !busy;
   assign row_ok  = 32'(req_data.row_tag) < MAX_TAGS;
   assign load_go = accept && (req_data.opcode == OP_LOAD) && row_ok;

   // tags in use, clamped to 1..MAX_TAGS
   always_comb begin
      n_use = tag_count_ff;
      if (tag_count_ff == 7'd0) n_use = 7'd1;
      if (32'(tag_count_ff) > MAX_TAGS) n_use = 7'(MAX_TAGS);
   end
   assign nm1 = TW'(n_use - 7'd1);

   assign busy   = (state_ff != S_IDLE);
   assign issue  = (state_ff == S_ACS) || (state_ff == S_FSCAN);
   assign pready = 1'b1;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_count_ff <= 7'd64;
         uniform_ff   <= 32'hFFFA_0000;
      end else if (psel && penable && pwrite) begin
         case (paddr)
            CSR_TAG_COUNT: tag_count_ff <= pwdata[6:0];
            CSR_UNIFORM:   uniform_ff   <= pwdata;
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         CSR_TAG_COUNT: prdata = {25'd0, tag_count_ff};
         CSR_UNIFORM:   prdata = uniform_ff;
         default:       prdata = 32'd0;
      endcase
   end

   // table memories: load beats write, the sequencer reads
   hbvt_ram #(.WIDTH(32), .DEPTH(MAX_TAGS)) u_begin (
      .clock(clock),
      .wr_en(load_go && req_data.table_select == TBL_BEGIN),
      .wr_addr(TW'(req_data.row_tag)), .wr_data(req_data.log_value),
      .rd_addr(i_ff), .rd_data(beg_rd));

   hbvt_ram #(.WIDTH(32), .DEPTH(MAX_TAGS)) u_end (
      .clock(clock),
      .wr_en(load_go && req_data.table_select == TBL_END),
      .wr_addr(TW'(req_data.row_tag)), .wr_data(req_data.log_value),
      .rd_addr(jiss_ff), .rd_data(end_rd));

   hbvt_ram #(.WIDTH(32), .DEPTH(TRD)) u_trans (
      .clock(clock),
      .wr_en(load_go && req_data.table_select == TBL_TRANS
             && 32'(req_data.column_index) < MAX_TAGS),
      .wr_addr(TRA'(32'(req_data.row_tag) * MAX_TAGS + 32'(req_data.column_index))),
      .wr_data(req_data.log_value),
      .rd_addr(TRA'(32'(jiss_ff) * MAX_TAGS + 32'(i_ff))), .rd_data(tr_rd));

   hbvt_ram #(.WIDTH(32), .DEPTH(EMD)) u_emit (
      .clock(clock),
      .wr_en(load_go && req_data.table_select == TBL_EMIT
             && 32'(req_data.column_index) < MAX_CLASSES),
      .wr_addr(EMA'(32'(req_data.row_tag) * MAX_CLASSES + 32'(req_data.column_index))),
      .wr_data(req_data.log_value),
      .rd_addr(EMA'(32'(i_ff) * MAX_CLASSES + 32'(wc_ff))), .rd_data(em_rd));

   hbvt_ram #(.WIDTH(32), .DEPTH(SFD)) u_suffix (
      .clock(clock),
      .wr_en(load_go && req_data.table_select == TBL_SUFFIX
             && 32'(req_data.column_index) < MAX_SUFFIXES),
      .wr_addr(SFA'(32'(req_data.row_tag) * MAX_SUFFIXES + 32'(req_data.column_index))),
      .wr_data(req_data.log_value),
      .rd_addr(SFA'(32'(i_ff) * MAX_SUFFIXES + 32'(si_ff))), .rd_data(sf_rd));

   // path scores: write row pos[0], read the other row (previous / final)
   hbvt_ram #(.WIDTH(LOG_WIDTH), .DEPTH(PSD)) u_path (
      .clock(clock),
      .wr_en(state_ff == S_WRITE),
      .wr_addr(PSA'(32'(pos_ff[0]) * MAX_TAGS + 32'(i_ff))),
      .wr_data(best_ff[LOG_WIDTH-1:0]),
      .rd_addr(PSA'(32'(!pos_ff[0]) * MAX_TAGS + 32'(jiss_ff))), .rd_data(ps_rd));

   hbvt_ram #(.WIDTH(TW), .DEPTH(BPD)) u_bptr (
      .clock(clock),
      .wr_en(state_ff == S_WRITE),
      .wr_addr(BPA'(32'(pos_ff) * MAX_TAGS + 32'(i_ff))), .wr_data(bj_ff),
      .rd_addr(BPA'(32'(p_ff) * MAX_TAGS + 32'(bj_ff))), .rd_data(bp_rd));

   // emission of the current tag, valid in S_ELAT, the state after S_EMIT
   always_comb begin
      if (dict_ff) begin
         e_conv = wc_ok_ff ? code_to_score(em_rd, LOG_LO, LOG_HI) : LOG_LO;
      end else if (suf_ok_ff) begin
         e_conv = code_to_score(sf_rd, LOG_LO, LOG_HI);
      end else begin
         e_conv = code_to_score(uniform_ff, LOG_LO, LOG_HI);
      end
   end

   // pipeline stage 1: candidate score from the memory read data
   assign s1_sum = sat_add3(score_type'($signed(ps_rd)),
                            code_to_score(fin_ff ? end_rd : tr_rd, LOG_LO, LOG_HI),
                            fin_ff ? score_type'(0) : e_ff, LOG_LO, LOG_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         l1_ff <= 1'b0;
         l2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         l1_ff <= issue && (jiss_ff == nm1);
         v2_ff <= v1_ff;
         l2_ff <= l1_ff;
      end
      j1_ff <= jiss_ff;
      j2_ff <= j1_ff;
      s2_ff <= s1_sum;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      jiss_in  = jiss_ff;
      p_in     = p_ff;
      best_in  = best_ff;
      bj_in    = bj_ff;

      // pipeline stage 2: compare, first strictly greater wins
      if (v2_ff && (j2_ff == '0 || s2_ff > best_ff)) begin
         best_in = s2_ff;
         bj_in   = j2_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.opcode == OP_WORD) begin
               i_in    = '0;
               jiss_in = '0;
               if (32'(pos_ff) < MAX_LEN) begin
                  state_in = S_EMIT;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = req_data.last_word ? S_FSCAN : S_IDLE;
               end
            end
         end
         S_EMIT: state_in = S_ELAT;
         S_ELAT: begin
            jiss_in = '0;
            if (pos_ff == '0) begin
               best_in  = sat_add3(code_to_score(beg_rd, LOG_LO, LOG_HI), e_conv,
                                   score_type'(0), LOG_LO, LOG_HI);
               state_in = S_WRITE;
            end else begin
               state_in = S_ACS;
            end
         end
         S_ACS: begin
            jiss_in = jiss_ff + TW'(1);
            if (jiss_ff == nm1) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (l2_ff) state_in = S_WRITE;
         end
         S_WRITE: begin
            jiss_in = '0;
            if (i_ff == nm1) begin
               pos_in   = pos_ff + PCW'(1);
               state_in = last_ff ? S_FSCAN : S_IDLE;
            end else begin
               i_in     = i_ff + TW'(1);
               state_in = S_EMIT;
            end
         end
         S_FSCAN: begin
            jiss_in = jiss_ff + TW'(1);
            if (jiss_ff == nm1) state_in = S_FDRAIN;
         end
         S_FDRAIN: begin
            if (l2_ff) begin
               p_in     = PW'(pos_ff - PCW'(1));
               state_in = S_BEMIT;
            end
         end
         S_BEMIT: begin
            if (p_ff == '0) begin
               pos_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_BWAIT;
            end
         end
         S_BWAIT: begin
            bj_in    = bp_rd;
            p_in     = p_ff - PW'(1);
            state_in = S_BEMIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         ovf_ff   <= ovf_in;
         fin_ff   <= (state_in == S_FSCAN) || (state_in == S_FDRAIN);
      end
      i_ff    <= i_in;
      jiss_ff <= jiss_in;
      p_ff    <= p_in;
      best_ff <= best_in;
      bj_ff   <= bj_in;
      if (state_ff == S_ELAT) e_ff <= e_conv;
      // word fields latched on the accepted beat
      if (accept) begin
         wc_ff     <= req_data.word_class;
         si_ff     <= req_data.suffix_index;
         dict_ff   <= req_data.in_dictionary;
         wc_ok_ff  <= 32'(req_data.word_class) < MAX_CLASSES;
         suf_ok_ff <= req_data.suffix_known && 32'(req_data.suffix_index) < MAX_SUFFIXES;
         last_ff   <= req_data.last_word;
      end
   end

   // result strobe during backtrack
   assign rsp_valid             = (state_ff == S_BEMIT);
   assign rsp_data.tag_out      = 6'(bj_ff);
   assign rsp_data.position_out = 6'(p_ff);
   assign rsp_data.last_out     = (p_ff == '0);
   assign rsp_data.overflow_out = ovf_ff;

`ifndef NO_ASSERTIONS
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_out |=> !busy) else $error("busy after final tag");
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.opcode == OP_WORD && req_data.last_word |=> busy)
      else $error("last word did not start decode");
   a_len_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pos_ff != '0) else $error("backtrack with empty sentence");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for hmm_bigram_viterbi_tagger: table loads, sentences and tags.
// Depends on hbvt_pkg and the tagger RTL; a built-in predictor gives most expected tags.
module tb;
   import hbvt_pkg::*;

   localparam longint LOG_LO = -64'sd2147483648;
   localparam longint LOG_HI = 64'sd2147483647;
   localparam int STALL_LIMIT = 20000;
   localparam int TB_TAGS = 4;

   typedef enum {ROW_BEAT, ROW_CSR} row_kind_type;
   typedef struct {
      row_kind_type kind;
      req_type      req;
      logic [2:0]   addr;
      logic [31:0]  data;
      bit           typed;
      rsp_type      want;
   } stim_row_type;

   logic        clock, reset, start, busy, rsp_valid;
   req_type     req_data;
   rsp_type     rsp_data;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   hmm_bigram_viterbi_tagger uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [31:0] begin_tbl [64];
   logic [31:0] end_tbl [64];
   logic [31:0] trans_tbl [64][64];
   logic [31:0] emit_tbl [logic [15:0]];
   logic [31:0] suffix_tbl [logic [17:0]];
   longint      path_score [2][64];
   logic [5:0]  back_ptr [64][64];
   int          word_pos;
   bit          overflow_seen;
   logic [6:0]  cfg_tags;
   logic [31:0] cfg_uniform;

   rsp_type tags_due [$];
   rsp_type got, want_now;
   int      miss_count;
   int      idle_pct;
   int      stall_cycles;

   logic [9:0]  class_pool [3];
   logic [11:0] suffix_pool [2];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint to_score(logic [31:0] u);
      if (u == ZERO_PROB_CODE) return LOG_LO;
      return longint'($signed(u));
   endfunction

   function automatic longint sum3(longint a, longint b, longint c);
      longint s;
      if (a == LOG_LO || b == LOG_LO || c == LOG_LO) return LOG_LO;
      s = a + b + c;
      if (s < LOG_LO) s = LOG_LO;
      if (s > LOG_HI) s = LOG_HI;
      return s;
   endfunction

   // one beat of the tagger: table write, or the ACS update for one word plus backtrack on the last word
   task automatic tagger_step(input req_type r, ref rsp_type res[$]);
      int n, cur, prv, len, tag, bj;
      logic [5:0] ti, tj;
      longint e, best, s;
      rsp_type o;
      n = (cfg_tags == 0) ? 1 : ((cfg_tags > 64) ? 64 : int'(cfg_tags));
      res.delete();
      if (r.opcode == OP_LOAD) begin
         case (r.table_select)
            TBL_BEGIN: begin_tbl[r.row_tag] = r.log_value;
            TBL_END:   end_tbl[r.row_tag] = r.log_value;
            TBL_TRANS: if (r.column_index < 64)
               trans_tbl[r.row_tag][r.column_index[5:0]] = r.log_value;
            TBL_EMIT: if (r.column_index < 1024)
               emit_tbl[{r.row_tag, r.column_index[9:0]}] = r.log_value;
            TBL_SUFFIX: suffix_tbl[{r.row_tag, r.column_index}] = r.log_value;
            default: ;
         endcase
         return;
      end
      if (word_pos < 64) begin
         cur = word_pos % 2;
         prv = cur ^ 1;
         for (int i = 0; i < n; i++) begin
            ti = 6'(i);
            if (r.in_dictionary) e = to_score(emit_tbl[{ti, r.word_class}]);
            else if (r.suffix_known) e = to_score(suffix_tbl[{ti, r.suffix_index}]);
            else e = to_score(cfg_uniform);
            if (word_pos == 0) begin
               path_score[cur][i] = sum3(to_score(begin_tbl[i]), e, 0);
            end else begin
               best = sum3(path_score[prv][0], to_score(trans_tbl[0][i]), e);
               bj = 0;
               for (int j = 1; j < n; j++) begin
                  s = sum3(path_score[prv][j], to_score(trans_tbl[j][i]), e);
                  if (s > best) begin
                     best = s;
                     bj = j;
                  end
               end
               path_score[cur][i] = best;
               back_ptr[word_pos][i] = 6'(bj);
            end
         end
         word_pos++;
      end else begin
         overflow_seen = 1'b1;
      end
      if (!r.last_word) return;
      // end weighting, best final tag, then walk back
      len = word_pos;
      cur = (len - 1) % 2;
      tag = 0;
      best = sum3(path_score[cur][0], to_score(end_tbl[0]), 0);
      for (int i = 1; i < n; i++) begin
         s = sum3(path_score[cur][i], to_score(end_tbl[i]), 0);
         if (s > best) begin
            best = s;
            tag = i;
         end
      end
      for (int p = len - 1; p >= 0; p--) begin
         o.tag_out = 6'(tag);
         o.position_out = 6'(p);
         o.last_out = (p == 0);
         o.overflow_out = overflow_seen;
         res.insert(res.size(), o);
         if (p > 0) begin
            tj = 6'(tag);
            tag = int'(back_ptr[p][tj]);
         end
      end
      word_pos = 0;
      overflow_seen = 1'b0;
   endtask

   task automatic report_miss(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      miss_count++;
   endtask

   // send one beat; entered and left at a falling edge
   task automatic send_beat(input req_type r, input bit typed, input rsp_type want);
      rsp_type res [$];
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      tagger_step(r, res);
      if (typed) tags_due.insert(tags_due.size(), want);
      else foreach (res[k]) tags_due.insert(tags_due.size(), res[k]);
      @(negedge clock);
   endtask

   // register write once the block has drained
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      start <= 1'b0;
      @(negedge clock);
      while (tags_due.size() != 0 || busy) @(negedge clock);
      repeat (2) @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == CSR_TAG_COUNT) cfg_tags = value[6:0];
      else cfg_uniform = value;
   endtask

   function automatic logic [31:0] rand_log();
      case ($urandom_range(7))
         0: return ZERO_PROB_CODE;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0001;
         3: return 32'h0;
         4, 5: return -($urandom_range(8) << 16);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_uniform();
      case ($urandom_range(3))
         0: return ZERO_PROB_CODE;
         1: return 32'h0;
         2: return -($urandom_range(8) << 16);
         default: return {1'b1, 31'($urandom)};
      endcase
   endfunction

   function automatic req_type load_beat(logic [2:0] sel, logic [5:0] row, logic [11:0] col,
                                         logic [31:0] value);
      req_type r;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.opcode = OP_LOAD;
      r.table_select = sel;
      r.row_tag = row;
      r.column_index = col;
      r.log_value = value;
      return r;
   endfunction

   function automatic req_type word_beat(logic [9:0] cls, bit dict, logic [11:0] sfx, bit sok,
                                         bit last);
      req_type r;
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.opcode = OP_WORD;
      r.word_class = cls;
      r.in_dictionary = dict;
      r.suffix_index = sfx;
      r.suffix_known = sok;
      r.last_word = last;
      return r;
   endfunction

   // random load: random row, mostly to valid entries, some ignored (bad column or table)
   function automatic req_type random_load();
      logic [5:0] row;
      row = 6'($urandom);
      case ($urandom_range(9))
         0: return load_beat(TBL_BEGIN, row, 12'($urandom), rand_log());
         1: return load_beat(TBL_END, row, 12'($urandom), rand_log());
         2, 3: return load_beat(TBL_TRANS, row, 12'($urandom_range(63)), rand_log());
         4: return load_beat(TBL_EMIT, row, 12'(class_pool[$urandom_range(2)]), rand_log());
         5: return load_beat(TBL_SUFFIX, row, 12'($urandom), rand_log());
         6: return load_beat(TBL_TRANS, row, 12'($urandom_range(4095, 64)), rand_log());
         7: return load_beat(TBL_EMIT, row, 12'($urandom_range(4095, 1024)), rand_log());
         8: return load_beat(3'($urandom_range(7, 5)), row, 12'($urandom), rand_log());
         default: return load_beat(TBL_SUFFIX, row, suffix_pool[$urandom_range(1)], rand_log());
      endcase
   endfunction

   function automatic req_type random_word(bit last);
      case ($urandom_range(3))
         0, 1: return word_beat(class_pool[$urandom_range(2)], 1'b1, 12'($urandom),
                                1'($urandom), last);
         2: return word_beat(10'($urandom), 1'b0, suffix_pool[$urandom_range(1)], 1'b1, last);
         default: return word_beat(10'($urandom), 1'b0, 12'($urandom), 1'b0, last);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got = rsp_data;
         if (tags_due.size() == 0) begin
            report_miss($sformatf("unexpected tag beat %p", got));
         end else begin
            want_now = tags_due.pop_front();
            if (got.tag_out !== want_now.tag_out)
               report_miss($sformatf("tag_out %0d, want %0d", got.tag_out, want_now.tag_out));
            if (got.position_out !== want_now.position_out)
               report_miss($sformatf("position_out %0d, want %0d",
                                     got.position_out, want_now.position_out));
            if (got.last_out !== want_now.last_out)
               report_miss($sformatf("last_out %b, want %b", got.last_out, want_now.last_out));
            if (got.overflow_out !== want_now.overflow_out)
               report_miss($sformatf("overflow_out %b, want %b",
                                     got.overflow_out, want_now.overflow_out));
         end
      end
   end

   // watchdog on cycles without any accepted beat or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[hmm_bigram_viterbi_tagger] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type w;
      rsp_type pos0;
      int      n_items, len, tc;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      miss_count = 0;
      idle_pct = 0;
      word_pos = 0;
      overflow_seen = 1'b0;
      cfg_tags = 7'd64;
      cfg_uniform = 32'hFFFA_0000;
      class_pool = '{10'd0, 10'd1023, 10'd682};
      suffix_pool = '{12'd0, 12'd4095};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register values after reset
      if (prdata !== 32'd64) report_miss("tag_count reset value");
      paddr <= CSR_UNIFORM;
      @(negedge clock);
      if (prdata !== 32'hFFFA_0000) report_miss("uniform reset value");

      // fill every entry that a word may read, for the tags the run uses
      csr_write(CSR_TAG_COUNT, 32'(TB_TAGS));
      for (int i = 0; i < TB_TAGS; i++) begin
         send_beat(load_beat(TBL_BEGIN, 6'(i), 12'($urandom), rand_log()), 1'b0, '0);
         send_beat(load_beat(TBL_END, 6'(i), 12'($urandom), rand_log()), 1'b0, '0);
         for (int j = 0; j < TB_TAGS; j++)
            send_beat(load_beat(TBL_TRANS, 6'(i), 12'(j), rand_log()), 1'b0, '0);
         foreach (class_pool[c])
            send_beat(load_beat(TBL_EMIT, 6'(i), 12'(class_pool[c]), rand_log()), 1'b0, '0);
         foreach (suffix_pool[c])
            send_beat(load_beat(TBL_SUFFIX, 6'(i), suffix_pool[c], rand_log()), 1'b0, '0);
      end

      // directed table
      pos0 = '{tag_out: 6'd0, position_out: 6'd0, last_out: 1'b1, overflow_out: 1'b0};
      w = '{ROW_BEAT, '0, '0, '0, 1'b0, '0};
      w.req = word_beat(10'd0, 1'b1, 12'd0, 1'b0, 1'b1); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_BEGIN, 6'd63, 12'd4095, 32'h7FFF_FFFF); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_END, 6'd0, 12'd0, ZERO_PROB_CODE); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_TRANS, 6'd63, 12'd63, 32'h8000_0001); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_EMIT, 6'd0, 12'd1023, 32'h0); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_SUFFIX, 6'd63, 12'd4095, 32'hFFFF_FFFF); rows.insert(rows.size(), w);
      w.req = load_beat(3'd7, 6'd5, 12'd5, 32'h0); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_TRANS, 6'd0, 12'd4095, 32'h0); rows.insert(rows.size(), w);
      w.req = load_beat(TBL_EMIT, 6'd0, 12'd1024, 32'h0); rows.insert(rows.size(), w);
      w.req = word_beat(10'd1023, 1'b0, 12'd4095, 1'b0, 1'b0); rows.insert(rows.size(), w);
      w.req = word_beat(10'd0, 1'b0, 12'd4095, 1'b1, 1'b0); rows.insert(rows.size(), w);
      w.req = word_beat(10'd1023, 1'b1, 12'd4095, 1'b1, 1'b1); rows.insert(rows.size(), w);
      w = '{ROW_CSR, '0, CSR_TAG_COUNT, 32'd1, 1'b0, '0}; rows.insert(rows.size(), w);
      w = '{ROW_BEAT, word_beat(10'd1023, 1'b1, 12'd0, 1'b0, 1'b1), '0, '0, 1'b1, pos0};
      rows.insert(rows.size(), w);
      w = '{ROW_CSR, '0, CSR_TAG_COUNT, 32'd0, 1'b0, '0}; rows.insert(rows.size(), w);
      w = '{ROW_BEAT, word_beat(10'd0, 1'b0, 12'd0, 1'b1, 1'b1), '0, '0, 1'b1, pos0};
      rows.insert(rows.size(), w);
      w = '{ROW_CSR, '0, CSR_UNIFORM, ZERO_PROB_CODE, 1'b0, '0}; rows.insert(rows.size(), w);
      w = '{ROW_BEAT, word_beat(10'd0, 1'b0, 12'd0, 1'b0, 1'b1), '0, '0, 1'b1, pos0};
      rows.insert(rows.size(), w);
      w = '{ROW_CSR, '0, CSR_TAG_COUNT, 32'd3, 1'b0, '0}; rows.insert(rows.size(), w);
      w = '{ROW_CSR, '0, CSR_UNIFORM, 32'h0, 1'b0, '0}; rows.insert(rows.size(), w);
      w = '{ROW_BEAT, word_beat(10'd0, 1'b0, 12'd0, 1'b1, 1'b1), '0, '0, 1'b0, '0};
      rows.insert(rows.size(), w);
      w = '{ROW_CSR, '0, CSR_TAG_COUNT, 32'd2, 1'b0, '0}; rows.insert(rows.size(), w);
      w = '{ROW_BEAT, word_beat(10'd0, 1'b0, 12'd0, 1'b0, 1'b0), '0, '0, 1'b0, '0};
      rows.insert(rows.size(), w);
      w.req = word_beat(10'd682, 1'b1, 12'd0, 1'b0, 1'b1); rows.insert(rows.size(), w);

      idle_pct = 37;
      foreach (rows[r]) begin
         if (rows[r].kind == ROW_CSR) csr_write(rows[r].addr, rows[r].data);
         else send_beat(rows[r].req, rows[r].typed, rows[r].want);
      end

      // random sentences in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 37 : ((ph == 1) ? 64 : 0);
         n_items = 0;
         while (n_items < 6) begin
            if ($urandom_range(3) == 0) begin
               case ($urandom_range(5))
                  0: tc = 1;
                  1: tc = 0;
                  default: tc = $urandom_range(TB_TAGS, 2);
               endcase
               csr_write(CSR_TAG_COUNT, 32'(tc));
               if ($urandom_range(1) == 1) csr_write(CSR_UNIFORM, rand_uniform());
            end
            len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(9) == 0) begin
                  send_beat(random_load(), 1'b0, '0);
                  n_items++;
               end
               send_beat(random_word(k == len - 1), 1'b0, '0);
               n_items++;
            end
            repeat ($urandom_range(3)) begin
               send_beat(random_load(), 1'b0, '0);
               n_items++;
            end
         end
      end

      // one sentence past the length limit
      len = 65;
      for (int k = 0; k < len; k++) send_beat(random_word(k == len - 1), 1'b0, '0);

      // drain
      start <= 1'b0;
      @(negedge clock);
      while (tags_due.size() != 0 || busy) @(negedge clock);
      repeat (50) @(negedge clock);
      if (miss_count == 0) begin
         $display("[hmm_bigram_viterbi_tagger] OK");
      end else begin
         $display("[hmm_bigram_viterbi_tagger] ERROR");
      end
      $finish;
   end

endmodule
